>>> sv/bis_pkg.sv
`default_nettype none
package bis_pkg;

   // operation codes carried on req_mode
   typedef enum logic [1:0] {
      MODE_ADD  = 2'd0,
      MODE_DEL  = 2'd1,
      MODE_TEST = 2'd2
   } mode_type;

   localparam int unsigned ITEM_ID_W   = 32;
   localparam int unsigned COUNT_OUT_W = 6;
   localparam logic [ITEM_ID_W-1:0] MARKER_RESET = '1;

endpackage
`default_nettype wire

>>> sv/bis_table.sv
`default_nettype none
module bis_table #(
   parameter int unsigned DEPTH = 32,
   parameter int unsigned KW    = 32,
   parameter int unsigned AW    = 5
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [KW-1:0] wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [KW-1:0] rd_data
);

   logic [KW-1:0] mem [DEPTH];
   logic [KW-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> sv/bounded_id_set_top.sv
// Flow: items settled at acceptance (bad mode, full add, empty delete, test of the
//   marker or of an empty set) are answered straight from idle; an add to an empty set
//   goes through S_ACT; otherwise add, test and a failed delete scan and then pass S_ACT,
//   and a successful delete adds S_DEL_WR; the scan reads at most count entries, one per cycle.
// Items are taken one at a time, and only while the block is idle.
// The receiver cannot stall; each result is a one-cycle strobe.
// Reset (synchronous, active high): set empty, marker back to all ones, table contents kept.
`default_nettype none
module bounded_id_set_top #(
   parameter int unsigned DEPTH    = 32,
   parameter int unsigned ID_WIDTH = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [1:0]                    req_mode,
   input  wire logic signed [bis_pkg::ITEM_ID_W-1:0] req_item_id,
   output logic                               rsp_valid,
   output logic                               rsp_status_code,
   output logic                               rsp_is_member,
   output logic [bis_pkg::COUNT_OUT_W-1:0]    rsp_entry_count,
   input  wire logic                          csr_we,
   input  wire logic signed [bis_pkg::ITEM_ID_W-1:0] csr_wdata
);

   import bis_pkg::*;

   // key width: identifiers compare on their low ID_WIDTH bits (at most 32) of a 32-bit field
   localparam int unsigned KW = (ID_WIDTH < ITEM_ID_W) ? ID_WIDTH : ITEM_ID_W;
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   typedef enum logic [1:0] {
      S_IDLE,    // waiting for an item
      S_SCAN,    // read entry idx, compare the one read last cycle
      S_ACT,     // decide, append, or fetch the last entry for a delete
      S_DEL_WR   // move the last entry into the freed slot
   } state_type;

   state_type         state_ff, state_in;
   mode_type          mode_ff, mode_in;
   logic [KW-1:0]     key_ff, key_in;
   logic [ITEM_ID_W-1:0] marker_ff, marker_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic [AW-1:0]     cmp_idx_ff, cmp_idx_in;
   logic              found_ff, found_in;
   logic [AW-1:0]     slot_ff, slot_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_status_ff, rsp_status_in;
   logic              rsp_member_ff, rsp_member_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;

   // table port signals
   logic              tbl_we;
   logic [AW-1:0]     tbl_wa;
   logic [KW-1:0]     tbl_wd;
   logic [AW-1:0]     tbl_ra;
   logic [KW-1:0]     tbl_rd;

   logic [KW-1:0]     req_key;
   logic [CW-1:0]     count_m1;
   logic [AW-1:0]     last_addr;
   logic              issue;
   logic [CW-1:0]     count_new;
   logic [CW+COUNT_OUT_W-1:0] count_ext;

   assign req_key   = req_item_id[KW-1:0];
   assign count_m1  = CW'(count_ff - 1'b1);
   assign last_addr = count_m1[AW-1:0];
   assign issue     = (idx_ff < count_ff);

   bis_table #(
      .DEPTH (DEPTH),
      .KW    (KW),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_wa),
      .wr_data (tbl_wd),
      .rd_addr (tbl_ra),
      .rd_data (tbl_rd)
   );

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      marker_in     = csr_we ? csr_wdata : marker_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = idx_ff[AW-1:0];
      found_in      = found_ff;
      slot_in       = slot_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_member_in = rsp_member_ff;
      count_new     = count_ff;
      tbl_we        = 1'b0;
      tbl_wa        = slot_ff;
      tbl_wd        = key_ff;
      tbl_ra        = idx_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               mode_in       = mode_type'(req_mode);
               key_in        = req_key;
               found_in      = 1'b0;
               idx_in        = '0;
               rsp_status_in = 1'b1;
               rsp_member_in = 1'b0;
               case (req_mode)
                  MODE_ADD: begin
                     if (count_ff == FULL_COUNT) begin
                        rsp_valid_in = 1'b1;
                     end else if (count_ff == '0) begin
                        state_in = S_ACT;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  MODE_DEL: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  MODE_TEST: begin
                     // the marker never tests present; an empty set holds nothing
                     if (req_key == marker_ff[KW-1:0] || count_ff == '0) begin
                        rsp_status_in = 1'b0;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         S_SCAN: begin
            // reads run ahead of the compare: each entry is compared in the cycle after its read
            if (issue) begin
               idx_in = CW'(idx_ff + 1'b1);
            end
            cmp_vld_in = issue;
            if (cmp_vld_ff) begin
               if (tbl_rd == key_ff) begin
                  found_in   = 1'b1;
                  slot_in    = cmp_idx_ff;
                  cmp_vld_in = 1'b0;
                  state_in   = S_ACT;
               end else if (cmp_idx_ff == last_addr) begin
                  cmp_vld_in = 1'b0;
                  state_in   = S_ACT;
               end
            end
         end

         S_ACT: begin
            state_in      = S_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_status_in = 1'b1;
            rsp_member_in = 1'b0;
            case (mode_ff)
               MODE_ADD: begin
                  if (!found_ff) begin
                     tbl_we        = 1'b1;
                     tbl_wa        = count_ff[AW-1:0];
                     tbl_wd        = key_ff;
                     count_new     = CW'(count_ff + 1'b1);
                     count_in      = count_new;
                     rsp_status_in = 1'b0;
                  end
               end
               MODE_DEL: begin
                  if (found_ff) begin
                     tbl_ra       = last_addr;
                     rsp_valid_in = 1'b0;
                     state_in     = S_DEL_WR;
                  end
               end
               MODE_TEST: begin
                  rsp_status_in = 1'b0;
                  rsp_member_in = found_ff;
               end
               default: begin
               end
            endcase
         end

         S_DEL_WR: begin
            tbl_we        = 1'b1;
            tbl_wa        = slot_ff;
            tbl_wd        = tbl_rd;
            count_new     = count_m1;
            count_in      = count_m1;
            rsp_status_in = 1'b0;
            rsp_valid_in  = 1'b1;
            state_in      = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // reported count is the set size after the item, low six bits
      count_ext    = {{COUNT_OUT_W{1'b0}}, count_new};
      rsp_count_in = count_ext[COUNT_OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         marker_ff    <= MARKER_RESET;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         marker_ff     <= marker_in;
         cmp_vld_ff    <= cmp_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
         mode_ff       <= mode_in;
         key_ff        <= key_in;
         idx_ff        <= idx_in;
         cmp_idx_ff    <= cmp_idx_in;
         found_ff      <= found_in;
         slot_ff       <= slot_in;
         rsp_status_ff <= rsp_status_in;
         rsp_member_ff <= rsp_member_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status_code = rsp_status_ff;
   assign rsp_is_member   = rsp_member_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule
`default_nettype wire

>>> sv/bis_checker.sv
`default_nettype none
module bis_checker #(
   parameter int unsigned DEPTH = 32
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          start,
   input wire logic                          busy,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_status_code,
   input wire logic                          rsp_is_member,
   input wire logic [bis_pkg::COUNT_OUT_W-1:0] rsp_entry_count
);

   // an accepted item either keeps the block busy or answers next cycle
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted item neither busy nor answered");

   // a result only follows an accepted item or work in progress
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy || start))
      else $error("result without an item");

   // membership is never reported with an error status
   a_member_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_member) |-> !rsp_status_code)
      else $error("member flagged with error status");

   // for DEPTH below 64, the set never reports more entries than it can hold
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (DEPTH >= 64 || rsp_entry_count <= DEPTH))
      else $error("entry count beyond depth");

endmodule

bind bounded_id_set_top bis_checker #(.DEPTH(DEPTH)) u_bis_checker (.*);
`default_nettype wire
